// ===== design/rbtc_pkg.sv =====
// Shared types, codes and constant tables of the radio band and tune controller.
package rbtc_pkg;

  localparam int unsigned FreqW   = 16;
  localparam int unsigned VolW    = 6;
  localparam int unsigned PollW   = 8;
  localparam int unsigned SbW     = 4;
  localparam int unsigned FiltW   = 9;
  localparam int unsigned ApbAw   = 5;
  localparam int unsigned ApbDw   = 32;
  localparam int unsigned TabSize = 13;

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_TUNE_UP  = 3'd1,
    KIND_TUNE_DN  = 3'd2,
    KIND_BAND     = 3'd3,
    KIND_INFO     = 3'd4,
    KIND_VOL_UP   = 3'd5,
    KIND_VOL_DN   = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_START    = 4'd1,
    CMD_TUNE     = 4'd2,
    CMD_VOLUME   = 4'd3,
    CMD_FILTER   = 4'd4,
    CMD_RDS      = 4'd5,
    CMD_POLL     = 4'd6,
    CMD_SHUTDOWN = 4'd7,
    CMD_BAND     = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_FM = 2'd0,
    MODE_AM = 2'd1,
    MODE_SW = 2'd2
  } mode_e;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_FM_LO    = 3'd0;
  localparam logic [2:0] REG_FM_HI    = 3'd1;
  localparam logic [2:0] REG_AM_LO    = 3'd2;
  localparam logic [2:0] REG_AM_HI    = 3'd3;
  localparam logic [2:0] REG_VOL_MAX  = 3'd4;
  localparam logic [2:0] REG_POLL_LIM = 3'd5;

  localparam logic [FreqW-1:0] FM_STEP   = 16'd10;
  localparam logic [FreqW-1:0] AM_STEP   = 16'd9;
  localparam logic [FreqW-1:0] SW_STEP   = 16'd5;
  localparam logic [FiltW-1:0] FILT_BASE = 9'h100;

  typedef struct packed {
    logic [FreqW-1:0] fm_lo;
    logic [FreqW-1:0] fm_hi;
    logic [FreqW-1:0] am_lo;
    logic [FreqW-1:0] am_hi;
    logic [VolW-1:0]  vol_max;
    logic [PollW-1:0] poll_lim;
  } cfg_t;

  typedef logic [FreqW-1:0] freq_tab_t [TabSize];

  localparam freq_tab_t SW_MIN_TAB = '{
    16'd2300, 16'd3200, 16'd3900, 16'd4750, 16'd5900, 16'd7100, 16'd9400,
    16'd11600, 16'd13500, 16'd15100, 16'd17480, 16'd18900, 16'd21450};

  localparam freq_tab_t SW_MAX_TAB = '{
    16'd2495, 16'd3400, 16'd4000, 16'd5060, 16'd6200, 16'd7450, 16'd9900,
    16'd12100, 16'd13870, 16'd15830, 16'd17900, 16'd19020, 16'd21850};

  // Sub-bands past the end of the table share its last entry.
  function automatic logic [FreqW-1:0] sw_min_f(input logic [SbW-1:0] sb);
    logic [SbW-1:0] idx;
    idx = (sb < SbW'(TabSize)) ? sb : SbW'(TabSize - 1);
    return SW_MIN_TAB[idx];
  endfunction

  function automatic logic [FreqW-1:0] sw_max_f(input logic [SbW-1:0] sb);
    logic [SbW-1:0] idx;
    idx = (sb < SbW'(TabSize)) ? sb : SbW'(TabSize - 1);
    return SW_MAX_TAB[idx];
  endfunction

endpackage

// ===== design/rbtc_ifs.sv =====
// Request and result channel interfaces of the radio band and tune controller.
interface rbtc_req_if;
  import rbtc_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic       long_press;
  logic       power_on;

  modport source (output valid, kind, long_press, power_on, input ready);
  modport sink   (input valid, kind, long_press, power_on, output ready);
endinterface

interface rbtc_res_if;
  import rbtc_pkg::*;

  logic             valid;
  logic             ready;
  logic [3:0]       command;
  logic [1:0]       band_mode;
  logic [SbW-1:0]   sw_band_index;
  logic [FreqW-1:0] frequency;
  logic [VolW-1:0]  volume_level;
  logic [FiltW-1:0] filter_code;
  logic             rds_shown;

  modport source (output valid, command, band_mode, sw_band_index, frequency,
                  volume_level, filter_code, rds_shown, input ready);
  modport sink   (input valid, command, band_mode, sw_band_index, frequency,
                  volume_level, filter_code, rds_shown, output ready);
endinterface

// ===== design/radio_band_tune_controller_top.sv =====
// Top level of the radio band and tune controller.
//
// Front-panel key events and timer ticks arrive as requests on req_i; each
// request yields exactly one result on res_o carrying a tuner command and
// a snapshot of the band, frequency, volume, filter and RDS display state.
// Both channels use valid/ready; a request or result moves at a rising edge
// where both are high. The limit registers are written over the APB port,
// which always answers with pready high; they should be changed only while
// no request is in flight.
// A request is captured in an input register, the whole state update is
// done in one pass of combinational logic, and the result is captured in an
// output register. One request per cycle is accepted as long as the result
// register is empty or being emptied, so a stalled receiver holds the result
// register and then, one request later, the input register, after which
// ready on req_i falls until res_o drains.
// The shortwave frequencies sit in a ring that rotates on each sub-band
// change, so the current sub-band is always at the head of the ring.
// Reset is asynchronous and active low: the radio is stopped in FM with all
// frequencies at the bottom of their bands, and both registers are emptied.
module radio_band_tune_controller_top #(
  parameter int unsigned SW_BAND_COUNT  = 13,
  parameter int unsigned FILTER_CHOICES = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rbtc_req_if.sink                   req_i,
  rbtc_res_if.source                 res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbtc_pkg::ApbAw-1:0] paddr,
  input  logic [rbtc_pkg::ApbDw-1:0] pwdata,
  output logic [rbtc_pkg::ApbDw-1:0] prdata,
  output logic                       pready
);
  import rbtc_pkg::*;

  localparam int unsigned FiW = (FILTER_CHOICES > 1) ? $clog2(FILTER_CHOICES) : 1;

  cfg_t cfg;

  rbtc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register.
  logic       in_vld_q;
  logic [2:0] in_kind_q;
  logic       in_long_q;
  logic       in_pwr_q;

  // Receiver state.
  logic             running_q, running_d;
  mode_e            mode_q, mode_d;
  logic [SbW-1:0]   sb_q, sb_d;
  logic [FreqW-1:0] fm_q, fm_d;
  logic [FreqW-1:0] am_q, am_d;
  logic [FreqW-1:0] ring_q [SW_BAND_COUNT];
  logic [FreqW-1:0] ring_d [SW_BAND_COUNT];
  logic [VolW-1:0]  vol_q, vol_d;
  logic [FiW-1:0]   am_fi_q, am_fi_d;
  logic [FiW-1:0]   sw_fi_q, sw_fi_d;
  logic             rds_q, rds_d;
  logic [PollW-1:0] poll_q, poll_d;

  // Result register.
  logic             out_vld_q;
  cmd_e             out_cmd_q;
  mode_e            out_mode_q;
  logic [SbW-1:0]   out_sb_q;
  logic [FreqW-1:0] out_freq_q;
  logic [VolW-1:0]  out_vol_q;
  logic [FiltW-1:0] out_filt_q;
  logic             out_rds_q;

  logic             out_free;
  logic             adv;
  cmd_e             cmd_d;
  logic [FreqW-1:0] freq_d;
  logic [FiltW-1:0] filt_d;

  // Stepper operands for the active band.
  logic [FreqW-1:0] st_freq, st_lo, st_hi, st_step, st_new;
  logic             st_changed;
  logic             rotate;
  logic             ring_we;
  logic [SbW-1:0]   sb_sum;
  logic [VolW:0]    vol_inc;
  logic [VolW-1:0]  vol_new;
  logic [PollW-1:0] poll_sum;
  logic [FiW:0]     am_fi_inc, sw_fi_inc;

  assign out_free    = !out_vld_q || res_o.ready;
  assign adv         = in_vld_q && out_free;
  assign req_i.ready = !in_vld_q || out_free;

  always_comb begin
    case (mode_q)
      MODE_AM: begin
        st_freq = am_q;
        st_lo   = cfg.am_lo;
        st_hi   = cfg.am_hi;
        st_step = AM_STEP;
      end
      MODE_SW: begin
        st_freq = ring_q[0];
        st_lo   = sw_min_f(sb_q);
        st_hi   = sw_max_f(sb_q);
        st_step = SW_STEP;
      end
      default: begin
        st_freq = fm_q;
        st_lo   = cfg.fm_lo;
        st_hi   = cfg.fm_hi;
        st_step = FM_STEP;
      end
    endcase
  end

  rbtc_freq_step u_step (
    .freq_i    (st_freq),
    .lo_i      (st_lo),
    .hi_i      (st_hi),
    .step_i    (st_step),
    .up_i      (in_kind_q == KIND_TUNE_UP),
    .freq_o    (st_new),
    .changed_o (st_changed)
  );

  assign sb_sum    = sb_q + 1'b1;
  assign vol_inc   = {1'b0, vol_q} + 1'b1;
  assign vol_new   = (vol_inc >= {1'b0, cfg.vol_max}) ? cfg.vol_max : vol_inc[VolW-1:0];
  assign poll_sum  = poll_q + 1'b1;
  assign am_fi_inc = {1'b0, am_fi_q} + 1'b1;
  assign sw_fi_inc = {1'b0, sw_fi_q} + 1'b1;

  // Next state and command for the request in the input register.
  always_comb begin
    running_d = running_q;
    mode_d    = mode_q;
    sb_d      = sb_q;
    fm_d      = fm_q;
    am_d      = am_q;
    vol_d     = vol_q;
    am_fi_d   = am_fi_q;
    sw_fi_d   = sw_fi_q;
    rds_d     = rds_q;
    poll_d    = poll_q;
    cmd_d     = CMD_NONE;
    rotate    = 1'b0;
    ring_we   = 1'b0;

    if (!running_q) begin
      // A stopped radio starts on any request that sees power; the key is dropped.
      if (in_pwr_q) begin
        running_d = 1'b1;
        cmd_d     = CMD_START;
      end
    end else if (!in_pwr_q) begin
      running_d = 1'b0;
      cmd_d     = CMD_SHUTDOWN;
    end else begin
      case (in_kind_q)
        KIND_TUNE_UP, KIND_TUNE_DN: begin
          if (st_changed) begin
            cmd_d = CMD_TUNE;
            case (mode_q)
              MODE_AM: am_d    = st_new;
              MODE_SW: ring_we = 1'b1;
              default: fm_d    = st_new;
            endcase
          end
        end
        KIND_BAND: begin
          if (!in_long_q) begin
            case (mode_q)
              MODE_FM: mode_d = MODE_AM;
              MODE_AM: mode_d = MODE_SW;
              default: begin
                // Next sub-band; past the last one the cycle returns to FM.
                rotate = 1'b1;
                if ({1'b0, sb_sum} >= (SbW+1)'(SW_BAND_COUNT)) begin
                  mode_d = MODE_FM;
                  sb_d   = '0;
                end else begin
                  sb_d = sb_sum;
                end
              end
            endcase
            running_d = 1'b0;
            cmd_d     = CMD_BAND;
          end
        end
        KIND_INFO: begin
          case (mode_q)
            MODE_AM: begin
              am_fi_d = (am_fi_inc >= (FiW+1)'(FILTER_CHOICES)) ? '0 : am_fi_inc[FiW-1:0];
              cmd_d   = CMD_FILTER;
            end
            MODE_SW: begin
              sw_fi_d = (sw_fi_inc >= (FiW+1)'(FILTER_CHOICES)) ? '0 : sw_fi_inc[FiW-1:0];
              cmd_d   = CMD_FILTER;
            end
            default: begin
              if (!in_long_q) begin
                rds_d = !rds_q;
                cmd_d = CMD_RDS;
              end
            end
          endcase
        end
        KIND_VOL_UP: begin
          if (vol_new != vol_q) begin
            vol_d = vol_new;
            cmd_d = CMD_VOLUME;
          end
        end
        KIND_VOL_DN: begin
          if (vol_q != '0) begin
            vol_d = vol_q - 1'b1;
            cmd_d = CMD_VOLUME;
          end
        end
        KIND_TICK: begin
          // Only FM ticks count towards a status poll.
          if (mode_q == MODE_FM) begin
            if (poll_sum > cfg.poll_lim) begin
              poll_d = '0;
              cmd_d  = CMD_POLL;
            end else begin
              poll_d = poll_sum;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Shortwave ring: head is the current sub-band, rotated on each sub-band change.
  always_comb begin
    for (int unsigned i = 0; i < SW_BAND_COUNT; i++) begin
      if (rotate) begin
        ring_d[i] = ring_q[(i == SW_BAND_COUNT - 1) ? 0 : i + 1];
      end else if (ring_we && i == 0) begin
        ring_d[i] = st_new;
      end else begin
        ring_d[i] = ring_q[i];
      end
    end
  end

  always_comb begin
    case (mode_d)
      MODE_AM: begin
        freq_d = am_d;
        filt_d = FILT_BASE + FiltW'(am_fi_d);
      end
      MODE_SW: begin
        freq_d = ring_d[0];
        filt_d = FILT_BASE + FiltW'(sw_fi_d);
      end
      default: begin
        freq_d = fm_d;
        filt_d = FILT_BASE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      running_q <= 1'b0;
      mode_q    <= MODE_FM;
      sb_q      <= '0;
      fm_q      <= 16'd8750;
      am_q      <= 16'd522;
      for (int unsigned i = 0; i < SW_BAND_COUNT; i++) begin
        ring_q[i] <= sw_min_f(SbW'(i));
      end
      vol_q     <= '0;
      am_fi_q   <= '0;
      sw_fi_q   <= '0;
      rds_q     <= 1'b0;
      poll_q    <= '0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        running_q <= running_d;
        mode_q    <= mode_d;
        sb_q      <= sb_d;
        fm_q      <= fm_d;
        am_q      <= am_d;
        ring_q    <= ring_d;
        vol_q     <= vol_d;
        am_fi_q   <= am_fi_d;
        sw_fi_q   <= sw_fi_d;
        rds_q     <= rds_d;
        poll_q    <= poll_d;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_kind_q <= req_i.kind;
      in_long_q <= req_i.long_press;
      in_pwr_q  <= req_i.power_on;
    end
    if (adv) begin
      out_cmd_q  <= cmd_d;
      out_mode_q <= mode_d;
      out_sb_q   <= sb_d;
      out_freq_q <= freq_d;
      out_vol_q  <= vol_d;
      out_filt_q <= filt_d;
      out_rds_q  <= rds_d;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.command       = out_cmd_q;
  assign res_o.band_mode     = out_mode_q;
  assign res_o.sw_band_index = out_sb_q;
  assign res_o.frequency     = out_freq_q;
  assign res_o.volume_level  = out_vol_q;
  assign res_o.filter_code   = out_filt_q;
  assign res_o.rds_shown     = out_rds_q;

  // A band change always leaves the radio stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && cmd_d == CMD_BAND) |=> !running_q)
    else $error("radio still running after a band change");

  // The current sub-band never reaches the sub-band count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, sb_q} < (SbW+1)'(SW_BAND_COUNT))
    else $error("shortwave sub-band out of range");

  // Filter indexes stay below the number of filter choices.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((FiW+1)'(am_fi_q) < (FiW+1)'(FILTER_CHOICES)) &&
    ((FiW+1)'(sw_fi_q) < (FiW+1)'(FILTER_CHOICES)))
    else $error("filter index out of range");

  // A request waiting behind a stalled result is held unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_free) |=> (in_vld_q && $stable(in_kind_q) && $stable(in_pwr_q)))
    else $error("pending request lost while the result was stalled");

endmodule

// ===== design/rbtc_cfg.sv =====
// APB register file holding the frequency limits, volume limit and poll limit.
module rbtc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rbtc_pkg::ApbAw-1:0] paddr,
  input  logic [rbtc_pkg::ApbDw-1:0] pwdata,
  output logic [rbtc_pkg::ApbDw-1:0] prdata,
  output logic                       pready,
  output rbtc_pkg::cfg_t             cfg_o
);
  import rbtc_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ApbAw-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fm_lo    <= 16'd8750;
      cfg_q.fm_hi    <= 16'd10790;
      cfg_q.am_lo    <= 16'd522;
      cfg_q.am_hi    <= 16'd1710;
      cfg_q.vol_max  <= 6'd63;
      cfg_q.poll_lim <= 8'd50;
    end else if (wr_en) begin
      case (idx)
        REG_FM_LO:    cfg_q.fm_lo    <= pwdata[FreqW-1:0];
        REG_FM_HI:    cfg_q.fm_hi    <= pwdata[FreqW-1:0];
        REG_AM_LO:    cfg_q.am_lo    <= pwdata[FreqW-1:0];
        REG_AM_HI:    cfg_q.am_hi    <= pwdata[FreqW-1:0];
        REG_VOL_MAX:  cfg_q.vol_max  <= pwdata[VolW-1:0];
        REG_POLL_LIM: cfg_q.poll_lim <= pwdata[PollW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_FM_LO:    prdata = ApbDw'(cfg_q.fm_lo);
      REG_FM_HI:    prdata = ApbDw'(cfg_q.fm_hi);
      REG_AM_LO:    prdata = ApbDw'(cfg_q.am_lo);
      REG_AM_HI:    prdata = ApbDw'(cfg_q.am_hi);
      REG_VOL_MAX:  prdata = ApbDw'(cfg_q.vol_max);
      REG_POLL_LIM: prdata = ApbDw'(cfg_q.poll_lim);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== design/rbtc_freq_step.sv =====
// Frequency stepper: adds or subtracts a step inside a band, wrapping past a limit.
module rbtc_freq_step (
  input  logic [rbtc_pkg::FreqW-1:0] freq_i,
  input  logic [rbtc_pkg::FreqW-1:0] lo_i,
  input  logic [rbtc_pkg::FreqW-1:0] hi_i,
  input  logic [rbtc_pkg::FreqW-1:0] step_i,
  input  logic                       up_i,
  output logic [rbtc_pkg::FreqW-1:0] freq_o,
  output logic                       changed_o
);
  import rbtc_pkg::*;

  always_comb begin
    freq_o = freq_i;
    if (up_i) begin
      // Below the top the step is added; above it the frequency wraps to the bottom.
      if (freq_i < hi_i) begin
        freq_o = freq_i + step_i;
      end else if (freq_i > hi_i) begin
        freq_o = lo_i;
      end
    end else begin
      if (freq_i > lo_i) begin
        freq_o = freq_i - step_i;
      end else if (freq_i < lo_i) begin
        freq_o = hi_i;
      end
    end
    changed_o = (freq_o != freq_i);
  end

endmodule
